>>> rtl/keyed_value_table_unit_defines.svh
// ----------------------------------------------------------------------------
// keyed_value_table_unit_defines
// Assertion macros shared by the keyed value table modules.
// ----------------------------------------------------------------------------
`ifndef KEYED_VALUE_TABLE_UNIT_DEFINES_SVH
`define KEYED_VALUE_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on i_clk, quiet while in reset
`define KVT_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kvt: same-cycle check failed");

// next-cycle implication, sampled on i_clk, quiet while in reset
`define KVT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kvt: next-cycle check failed");

`endif

>>> rtl/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Widths, request and status codes, and controller/datapath link types.
// ----------------------------------------------------------------------------
package kvt_pkg;

    // payload field widths
    localparam int REQ_TYPE_W   = 3;
    localparam int REQ_KEY_W    = 32;
    localparam int REQ_VALUE_W  = 32;
    localparam int STATUS_W     = 2;
    localparam int FOUND_W      = 32;
    localparam int COUNT_W      = 6;

    // parameter defaults
    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_VALUE_BITS  = 32;

    // request kinds
    typedef enum logic [REQ_TYPE_W-1:0] {
        OP_INSERT = 3'd0,
        OP_ERASE  = 3'd1,
        OP_GET    = 3'd2,
        OP_COUNT  = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_FULL    = 2'd1,
        STS_DUP     = 2'd2,
        STS_MISSING = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic start;       // latch request, rewind the walk
        logic walk;        // advance the walk pointer one slot
        logic shift;       // walk moves entries down instead of comparing
        logic shift_init;  // point the walk just past the hit slot
        logic commit;      // apply the update and load the response
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_done;   // all slots issued and pipeline drained
        logic hit;         // key found during the scan
        logic is_erase;    // latched request is an erase
        logic out_free;    // response register can take a new result
    } t_dp_status;

endpackage

>>> rtl/kvt_if.sv
// ----------------------------------------------------------------------------
// kvt request and response interfaces
// Valid/ready channels carrying the table request and its result.
// ----------------------------------------------------------------------------
interface kvt_req_if;
    logic                              valid;
    logic                              ready;
    logic [kvt_pkg::REQ_TYPE_W-1:0]    req_type;
    logic [kvt_pkg::REQ_KEY_W-1:0]     req_key;
    logic [kvt_pkg::REQ_VALUE_W-1:0]   req_value;

    modport source (output valid, output req_type, output req_key, output req_value,
                    input ready);
    modport sink   (input valid, input req_type, input req_key, input req_value,
                    output ready);
endinterface

interface kvt_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [kvt_pkg::STATUS_W-1:0]      status;
    logic [kvt_pkg::FOUND_W-1:0]       found_value;
    logic [kvt_pkg::COUNT_W-1:0]       match_count;
    logic [kvt_pkg::COUNT_W-1:0]       entries_used;

    modport source (output valid, output status, output found_value,
                    output match_count, output entries_used, input ready);
    modport sink   (input valid, input status, input found_value,
                    input match_count, input entries_used, output ready);
endinterface

>>> rtl/kvt_ram.sv
// ----------------------------------------------------------------------------
// kvt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/kvt_datapath.sv
// ----------------------------------------------------------------------------
// kvt_datapath
// Key and value memories, walk pointer, compare logic and result register.
// ----------------------------------------------------------------------------
`include "keyed_value_table_unit_defines.svh"

module kvt_datapath #(
    parameter int TABLE_DEPTH = kvt_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = kvt_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS  = kvt_pkg::DEF_VALUE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [kvt_pkg::REQ_TYPE_W-1:0]   i_req_type,
    input  logic [kvt_pkg::REQ_KEY_W-1:0]    i_req_key,
    input  logic [kvt_pkg::REQ_VALUE_W-1:0]  i_req_value,
    input  kvt_pkg::t_dp_cmd                 i_cmd,
    output kvt_pkg::t_dp_status              o_status,
    input  logic                             i_rsp_ready,
    output logic                             o_rsp_valid,
    output logic [kvt_pkg::STATUS_W-1:0]     o_rsp_status,
    output logic [kvt_pkg::FOUND_W-1:0]      o_rsp_found_value,
    output logic [kvt_pkg::COUNT_W-1:0]      o_rsp_match_count,
    output logic [kvt_pkg::COUNT_W-1:0]      o_rsp_entries_used
);
    import kvt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] DEPTH_CNT = IW'(TABLE_DEPTH);

    // latched request
    logic [REQ_TYPE_W-1:0]  r_op,  n_op;
    logic [KEY_BITS-1:0]    r_key, n_key;
    logic [VALUE_BITS-1:0]  r_val, n_val;

    // table occupancy and walk state
    logic [IW-1:0]          r_fill,    n_fill;
    logic [IW-1:0]          r_rd_idx,  n_rd_idx;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]          r_cmp_idx, n_cmp_idx;
    logic                   r_hit,     n_hit;
    logic [AW-1:0]          r_pos,     n_pos;
    logic [VALUE_BITS-1:0]  r_found,   n_found;
    logic [IW-1:0]          r_cnt,     n_cnt;

    // response register
    logic                   r_rsp_vld,    n_rsp_vld;
    logic [STATUS_W-1:0]    r_rsp_status, n_rsp_status;
    logic [FOUND_W-1:0]     r_rsp_found,  n_rsp_found;
    logic [COUNT_W-1:0]     r_rsp_match,  n_rsp_match;
    logic [COUNT_W-1:0]     r_rsp_used,   n_rsp_used;

    // memory ports
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [KEY_BITS-1:0]    w_wkey;
    logic [VALUE_BITS-1:0]  w_wval;
    logic [KEY_BITS-1:0]    w_rkey;
    logic [VALUE_BITS-1:0]  w_rval;
    logic                   w_issue;

    kvt_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wkey),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rkey)
    );

    kvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_DEPTH)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wval),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rval)
    );

    // next-state logic for walk, compare, update and response
    always_comb begin
        n_op         = r_op;
        n_key        = r_key;
        n_val        = r_val;
        n_fill       = r_fill;
        n_rd_idx     = r_rd_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_hit        = r_hit;
        n_pos        = r_pos;
        n_found      = r_found;
        n_cnt        = r_cnt;
        n_rsp_vld    = r_rsp_vld;
        n_rsp_status = r_rsp_status;
        n_rsp_found  = r_rsp_found;
        n_rsp_match  = r_rsp_match;
        n_rsp_used   = r_rsp_used;
        w_we         = 1'b0;
        w_waddr      = r_cmp_idx - AW'(1);
        w_wkey       = w_rkey;
        w_wval       = w_rval;
        w_issue      = (r_rd_idx < r_fill);

        // new request
        if (i_cmd.start) begin
            n_op      = i_req_type;
            n_key     = KEY_BITS'(i_req_key);
            n_val     = VALUE_BITS'(i_req_value);
            n_rd_idx  = '0;
            n_cmp_vld = 1'b0;
            n_hit     = 1'b0;
            n_cnt     = '0;
            n_found   = '0;
        end

        // erase: restart the walk one past the removed slot
        if (i_cmd.shift_init) begin
            n_rd_idx  = IW'(r_pos) + IW'(1);
            n_cmp_vld = 1'b0;
        end

        // one slot per cycle, data compared in the cycle after its read
        if (i_cmd.walk) begin
            n_cmp_vld = w_issue;
            n_cmp_idx = r_rd_idx[AW-1:0];
            if (w_issue) begin
                n_rd_idx = r_rd_idx + IW'(1);
            end
            if (r_cmp_vld) begin
                if (i_cmd.shift) begin
                    w_we = 1'b1;
                end else begin
                    if ((w_rkey == r_key) && !r_hit) begin
                        n_hit   = 1'b1;
                        n_pos   = r_cmp_idx;
                        n_found = w_rval;
                    end
                    if (w_rval == r_val) begin
                        n_cnt = r_cnt + IW'(1);
                    end
                end
            end
        end

        // response taken downstream
        if (r_rsp_vld && i_rsp_ready) begin
            n_rsp_vld = 1'b0;
        end

        // apply the update and load the result
        if (i_cmd.commit) begin
            n_rsp_vld    = 1'b1;
            n_rsp_status = STS_OK;
            n_rsp_found  = '0;
            n_rsp_match  = '0;
            case (r_op)
                OP_INSERT: begin
                    if (r_fill == DEPTH_CNT) begin
                        n_rsp_status = STS_FULL;
                    end else if (r_hit) begin
                        n_rsp_status = STS_DUP;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_fill[AW-1:0];
                        w_wkey  = r_key;
                        w_wval  = r_val;
                        n_fill  = r_fill + IW'(1);
                    end
                end
                OP_ERASE: begin
                    if (!r_hit) begin
                        n_rsp_status = STS_MISSING;
                    end else begin
                        n_fill = r_fill - IW'(1);
                    end
                end
                OP_GET: begin
                    if (!r_hit) begin
                        n_rsp_status = STS_MISSING;
                    end else begin
                        n_rsp_found = FOUND_W'(r_found);
                    end
                end
                OP_COUNT: begin
                    n_rsp_match = COUNT_W'(r_cnt);
                end
                OP_CLEAR: begin
                    n_fill = '0;
                end
                default: begin
                end
            endcase
            n_rsp_used = COUNT_W'(n_fill);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_fill    <= n_fill;
            r_rd_idx  <= n_rd_idx;
            r_cmp_vld <= n_cmp_vld;
            r_hit     <= n_hit;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_val        <= n_val;
        r_cmp_idx    <= n_cmp_idx;
        r_pos        <= n_pos;
        r_found      <= n_found;
        r_cnt        <= n_cnt;
        r_rsp_status <= n_rsp_status;
        r_rsp_found  <= n_rsp_found;
        r_rsp_match  <= n_rsp_match;
        r_rsp_used   <= n_rsp_used;
    end

    // status back to the controller
    assign o_status.walk_done = (r_rd_idx == r_fill) && !r_cmp_vld;
    assign o_status.hit       = r_hit;
    assign o_status.is_erase  = (r_op == OP_ERASE);
    assign o_status.out_free  = !r_rsp_vld || i_rsp_ready;

    assign o_rsp_valid        = r_rsp_vld;
    assign o_rsp_status       = r_rsp_status;
    assign o_rsp_found_value  = r_rsp_found;
    assign o_rsp_match_count  = r_rsp_match;
    assign o_rsp_entries_used = r_rsp_used;

    // checks
    `KVT_ASSERT_IMPL(a_fill_bound, 1'b1, r_fill <= DEPTH_CNT)
    `KVT_ASSERT_IMPL(a_shift_below_fill, i_cmd.shift && w_we, IW'(r_cmp_idx) < r_fill)
    `KVT_ASSERT_NEXT(a_commit_loads_rsp, i_cmd.commit, r_rsp_vld)
endmodule

>>> rtl/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// kvt_ctrl
// Request sequencer: scan, optional shift on erase, then result commit.
// ----------------------------------------------------------------------------
`include "keyed_value_table_unit_defines.svh"

module kvt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  kvt_pkg::t_dp_status  i_status,
    output kvt_pkg::t_dp_cmd     o_cmd
);
    import kvt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // state transitions and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_done) begin
                    if (i_status.is_erase && i_status.hit) begin
                        o_cmd.shift_init = 1'b1;
                        n_state          = ST_SHIFT;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SHIFT: begin
                o_cmd.walk  = 1'b1;
                o_cmd.shift = 1'b1;
                if (i_status.walk_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // checks
    `KVT_ASSERT_IMPL(a_commit_needs_room, o_cmd.commit, i_status.out_free)
    `KVT_ASSERT_NEXT(a_start_to_scan, o_cmd.start, r_state == ST_SCAN)
    `KVT_ASSERT_IMPL(a_shift_on_erase_hit, r_state == ST_SHIFT, i_status.is_erase && i_status.hit)
endmodule

>>> rtl/keyed_value_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_value_table_unit
// Bounded key/value table kept as a packed list in two RAMs.
//
//   channel   dir   payload                                         handshake
//   i_req     in    req_type, req_key, req_value                    valid/ready
//   o_rsp     out   status, found_value, match_count, entries_used  valid/ready
//
// One request at a time; every request walks the occupied slots through the
// RAM read port, one slot per cycle.
// An erase that hits adds a second walk that moves the later entries down.
// Reset clears the entry count and the walk and response state, not the RAMs;
// no memory clearing pass is needed. A stalled result sits in the output
// register; the next request is taken meanwhile and only its commit waits for the register to drain.
// ----------------------------------------------------------------------------
module keyed_value_table_unit #(
    parameter int TABLE_DEPTH = kvt_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = kvt_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS  = kvt_pkg::DEF_VALUE_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    kvt_req_if.sink    i_req,
    kvt_rsp_if.source  o_rsp
);
    import kvt_pkg::*;

    t_dp_cmd     w_cmd;
    t_dp_status  w_status;
    logic        w_req_ready;

    // sequencer
    kvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // storage and compare
    kvt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_type         (i_req.req_type),
        .i_req_key          (i_req.req_key),
        .i_req_value        (i_req.req_value),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_rsp_ready        (o_rsp.ready),
        .o_rsp_valid        (o_rsp.valid),
        .o_rsp_status       (o_rsp.status),
        .o_rsp_found_value  (o_rsp.found_value),
        .o_rsp_match_count  (o_rsp.match_count),
        .o_rsp_entries_used (o_rsp.entries_used)
    );

    assign i_req.ready = w_req_ready;
endmodule

>>> dv/tb_keyed_value_table_unit.sv
// ----------------------------------------------------------------------------
// tb_keyed_value_table_unit
// Self-checking bench for the keyed value table. A clocked driver offers
// requests from a queue with random gaps, a clocked monitor takes results
// with random stalls and one long hold-off, and a shadow table predicts the
// status, value, match count and entry count of every accepted request.
// ----------------------------------------------------------------------------
module tb_keyed_value_table_unit;
    import kvt_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    localparam int DEPTH        = DEF_TABLE_DEPTH;
    localparam int ITEMS_TOTAL  = 1100;
    localparam int MAX_GAP      = 17;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int IDLE_LIMIT   = 5000;
    localparam int REPORT_MAX   = 10;
    localparam int KEY_POOL_N   = 40;
    localparam int VAL_POOL_N   = 8;
    localparam int KIND_CODES   = 1 << REQ_TYPE_W;

    typedef struct {
        logic [REQ_TYPE_W-1:0]  kind;
        logic [REQ_KEY_W-1:0]   key;
        logic [REQ_VALUE_W-1:0] value;
        int unsigned            gap;
    } t_table_req;

    typedef struct {
        t_status              status;
        logic [FOUND_W-1:0]   found;
        logic [COUNT_W-1:0]   match_cnt;
        logic [COUNT_W-1:0]   used;
    } t_table_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kvt_req_if req_ch ();
    kvt_rsp_if rsp_ch ();

    keyed_value_table_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow copy of the table
    logic [REQ_KEY_W-1:0]   shadow_keys [DEPTH];
    logic [REQ_VALUE_W-1:0] shadow_vals [DEPTH];
    int                     shadow_fill;

    t_table_req pending_reqs [$];
    t_table_rsp expected_rsps [$];

    logic [REQ_KEY_W-1:0]   key_pool [KEY_POOL_N];
    logic [REQ_VALUE_W-1:0] val_pool [VAL_POOL_N];
    bit                     seq_gapless;

    t_table_req  offer_item;
    bit          offer_busy;
    int unsigned wait_left;

    int unsigned stall_left;
    bit          rsp_calm;
    int          results_seen;
    int          fail_count;
    int          idle_cycles;

    // apply one request to the shadow table and return its result
    function automatic t_table_rsp table_apply(input t_table_req rq);
        t_table_rsp rs;
        int         hit_pos;
        rs.status    = STS_OK;
        rs.found     = '0;
        rs.match_cnt = '0;
        hit_pos      = -1;
        for (int i = 0; i < shadow_fill; i++) begin
            if (hit_pos < 0 && shadow_keys[i] == rq.key) hit_pos = i;
        end
        case (rq.kind)
            OP_INSERT: begin
                // fullness wins over a duplicate key
                if (shadow_fill >= DEPTH) begin
                    rs.status = STS_FULL;
                end else if (hit_pos >= 0) begin
                    rs.status = STS_DUP;
                end else begin
                    shadow_keys[shadow_fill] = rq.key;
                    shadow_vals[shadow_fill] = rq.value;
                    shadow_fill++;
                end
            end
            OP_ERASE: begin
                if (hit_pos < 0) begin
                    rs.status = STS_MISSING;
                end else begin
                    for (int i = hit_pos; i + 1 < shadow_fill; i++) begin
                        shadow_keys[i] = shadow_keys[i + 1];
                        shadow_vals[i] = shadow_vals[i + 1];
                    end
                    shadow_fill--;
                end
            end
            OP_GET: begin
                if (hit_pos < 0) rs.status = STS_MISSING;
                else rs.found = shadow_vals[hit_pos];
            end
            OP_COUNT: begin
                for (int i = 0; i < shadow_fill; i++) begin
                    if (shadow_vals[i] == rq.value) rs.match_cnt++;
                end
            end
            OP_CLEAR: begin
                shadow_fill = 0;
            end
            default: begin
                // unused codes leave the table alone
            end
        endcase
        rs.used = COUNT_W'(shadow_fill);
        return rs;
    endfunction

    // queue one request with a gap drawn for the current sequence
    task automatic push_req(input logic [REQ_TYPE_W-1:0] kind,
                            input logic [REQ_KEY_W-1:0] key,
                            input logic [REQ_VALUE_W-1:0] value);
        t_table_req rq;
        rq.kind  = kind;
        rq.key   = key;
        rq.value = value;
        rq.gap   = seq_gapless ? 0 : $urandom_range(0, MAX_GAP);
        pending_reqs.push_back(rq);
    endtask

    function automatic logic [REQ_KEY_W-1:0] pool_key();
        return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    endfunction

    function automatic logic [REQ_VALUE_W-1:0] pool_val();
        return val_pool[$urandom_range(0, VAL_POOL_N - 1)];
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            offer_busy = 1'b0;
            wait_left  = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_rsps.push_back(table_apply(offer_item));
                offer_busy = 1'b0;
            end
            if (!offer_busy && pending_reqs.size() > 0) begin
                offer_item = pending_reqs.pop_front();
                offer_busy = 1'b1;
                wait_left  = offer_item.gap;
            end
            if (offer_busy && wait_left == 0) begin
                req_ch.valid     <= 1'b1;
                req_ch.req_type  <= offer_item.kind;
                req_ch.req_key   <= offer_item.key;
                req_ch.req_value <= offer_item.value;
            end else begin
                req_ch.valid <= 1'b0;
                if (offer_busy) wait_left--;
            end
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        t_table_rsp exp_rsp;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, MAX_GAP);
            rsp_calm   = 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                results_seen++;
                if (expected_rsps.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected result: status %0d found %h count %0d used %0d",
                                 rsp_ch.status, rsp_ch.found_value, rsp_ch.match_count,
                                 rsp_ch.entries_used);
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (rsp_ch.status !== exp_rsp.status ||
                        rsp_ch.found_value !== exp_rsp.found ||
                        rsp_ch.match_count !== exp_rsp.match_cnt ||
                        rsp_ch.entries_used !== exp_rsp.used) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display(
                                "#%0d exp/act st %0d/%0d val %h/%h cnt %0d/%0d used %0d/%0d",
                                results_seen, exp_rsp.status, rsp_ch.status,
                                exp_rsp.found, rsp_ch.found_value,
                                exp_rsp.match_cnt, rsp_ch.match_count,
                                exp_rsp.used, rsp_ch.entries_used);
                    end
                end
                // one long hold-off so the block backs up into its input
                if (results_seen == HOLD_AT) stall_left = HOLD_CYCLES;
                else stall_left = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 15) == 0) rsp_calm = !rsp_calm;
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int                     seq_idx;
        int                     pick;
        logic [REQ_KEY_W-1:0]   last_key;
        logic [REQ_VALUE_W-1:0] v;

        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = OP_INSERT;
        req_ch.req_key   = '0;
        req_ch.req_value = '0;
        rsp_ch.ready     = 1'b0;
        shadow_fill      = 0;
        results_seen     = 0;
        fail_count       = 0;
        idle_cycles      = 0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = $urandom;
        val_pool[0] = '0;
        val_pool[1] = '1;
        for (int i = 2; i < VAL_POOL_N; i++) val_pool[i] = $urandom;

        // directed: empty table, extremes, duplicates, shifts, unused codes
        seq_gapless = 1'b0;
        push_req(OP_GET,    '0, '0);
        push_req(OP_ERASE,  '1, '0);
        push_req(OP_COUNT,  '0, '0);
        push_req(OP_CLEAR,  '0, '0);
        push_req(OP_INSERT, '0, '1);
        push_req(OP_INSERT, '1, '0);
        push_req(OP_INSERT, '0, 32'd1);
        push_req(OP_INSERT, 32'h1234_5678, '1);
        push_req(OP_GET,    '0, '0);
        push_req(OP_GET,    '1, '0);
        push_req(OP_COUNT,  '0, '1);
        push_req(OP_COUNT,  '0, '0);
        push_req(OP_ERASE,  '0, '0);
        push_req(OP_GET,    '0, '0);
        push_req(OP_GET,    32'h1234_5678, '0);
        push_req(OP_ERASE,  32'h1234_5678, '0);
        for (int k = int'(OP_CLEAR) + 1; k < KIND_CODES; k++)
            push_req(REQ_TYPE_W'(k), '1, '1);
        push_req(OP_CLEAR,  '0, '0);
        push_req(OP_GET,    '1, '0);
        push_req(OP_INSERT, '1, 32'hA5A5_A5A5);
        push_req(OP_COUNT,  '0, 32'hA5A5_A5A5);

        // random sequences
        seq_idx = 0;
        while (pending_reqs.size() < ITEMS_TOTAL) begin
            seq_gapless = ($urandom_range(0, 9) < 3);
            if (seq_idx == 0) pick = 0;
            else if (seq_idx == 1) pick = 1;
            else pick = $urandom_range(2, 19);
            seq_idx++;
            if (pick == 0 || pick == 2) begin
                // fill past capacity, then repeat the last key on a full table
                if ($urandom_range(0, 1) == 1) push_req(OP_CLEAR, '0, '0);
                for (int n = 0; n < DEPTH + 2; n++) begin
                    last_key = $urandom;
                    push_req(OP_INSERT, last_key,
                             ($urandom_range(0, 1) == 1) ? pool_val() : $urandom);
                end
                push_req(OP_INSERT, last_key, pool_val());
                push_req(OP_GET, last_key, '0);
                push_req(OP_COUNT, '0, pool_val());
                push_req(OP_ERASE, last_key, '0);
                push_req(OP_GET, last_key, '0);
            end else if (pick == 1 || pick == 3) begin
                // every entry holds the same value
                push_req(OP_CLEAR, '0, '0);
                v = pool_val();
                for (int n = 0; n <= DEPTH; n++) push_req(OP_INSERT, $urandom, v);
                push_req(OP_COUNT, '0, v);
                push_req(OP_COUNT, '0, pool_val());
                push_req(OP_GET, pool_key(), '0);
            end else if (pick < 6) begin
                // erase sweep over the pool, each erase followed by a get
                for (int n = 0; n < 12; n++)
                    push_req((n % 2 == 0) ? OP_ERASE : OP_GET, pool_key(), '0);
            end else if (pick < 8) begin
                // noise: any code, any bits
                for (int n = 0; n < 8; n++)
                    push_req(REQ_TYPE_W'($urandom_range(0, KIND_CODES - 1)), $urandom, $urandom);
            end else begin
                // mixed traffic, mostly on pool keys
                for (int n = 0; n < 20; n++) begin
                    pick = $urandom_range(0, 99);
                    last_key = ($urandom_range(0, 4) == 0) ? $urandom : pool_key();
                    v = ($urandom_range(0, 9) < 7) ? pool_val() : $urandom;
                    if (pick < 42)      push_req(OP_INSERT, last_key, v);
                    else if (pick < 57) push_req(OP_ERASE, last_key, v);
                    else if (pick < 77) push_req(OP_GET, last_key, v);
                    else if (pick < 93) push_req(OP_COUNT, last_key, v);
                    else if (pick < 96) push_req(OP_CLEAR, last_key, v);
                    else push_req(REQ_TYPE_W'($urandom_range(int'(OP_CLEAR) + 1,
                                                             KIND_CODES - 1)), last_key, v);
                end
            end
        end

        // reset
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request to be taken and answered
        @(posedge i_clk);
        while (pending_reqs.size() != 0 || offer_busy || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_rsps.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> keyed_value_table_unit.f
+incdir+rtl
rtl/kvt_pkg.sv
rtl/kvt_if.sv
rtl/kvt_ram.sv
rtl/kvt_datapath.sv
rtl/kvt_ctrl.sv
rtl/keyed_value_table_unit.sv
dv/tb_keyed_value_table_unit.sv
